@@ rtl/core/mlrq_pkg.sv @@
// Package for the multilevel ready queue: field widths, operation and status codes,
// configuration register indexes and the result record.
// No dependencies.
`default_nettype none

package mlrq_pkg;

    // Field widths of the command and result ports.
    localparam int OPCODE_W   = 1;
    localparam int PID_W      = 16;
    localparam int PRIO_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int PLVL_W     = 3;
    localparam int HLVL_W     = 4;
    localparam int WAIT_W     = 8;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int LCNT_W     = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd1;

    // Operation codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PRIO = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Result record passed from the queue control to the result stage.
    typedef struct packed {
        status_t             status;
        logic                pop_ok;
        logic [PLVL_W-1:0]   popped_level;
        logic [HLVL_W-1:0]   highest_level;
        logic [WAIT_W-1:0]   waiting_total;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/mlrq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the id store of the multilevel ready queue; no dependencies.
`default_nettype none

module mlrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/mlrq_ctrl.sv @@
// Queue control: configuration registers, per-level head, tail and fill counts,
// push and pop decisions and the id store requests. Depends on mlrq_pkg.
`default_nettype none

module mlrq_ctrl #(
    parameter int MAX_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_we,
    input  wire logic [mlrq_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [mlrq_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  wire logic                                        accept,
    input  wire logic [mlrq_pkg::OPCODE_W-1:0]               opcode,
    input  wire logic [mlrq_pkg::PID_W-1:0]                  process_id,
    input  wire logic [mlrq_pkg::PRIO_W-1:0]                 priority_req,
    output logic                                             ram_we,
    output logic [$clog2(MAX_LEVELS*LEVEL_DEPTH)-1:0]        ram_waddr,
    output logic [mlrq_pkg::PID_W-1:0]                       ram_wdata,
    output logic                                             ram_re,
    output logic [$clog2(MAX_LEVELS*LEVEL_DEPTH)-1:0]        ram_raddr,
    output mlrq_pkg::res_t                                   res_next
);

    import mlrq_pkg::*;

    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LCW    = $clog2(MAX_LEVELS + 1);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
    localparam int TOT_W  = $clog2(MAX_LEVELS * LEVEL_DEPTH + 1);
    localparam int AW     = $clog2(MAX_LEVELS * LEVEL_DEPTH);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LEVEL_DEPTH);
    localparam logic [7:0]        MAXL_8   = 8'(MAX_LEVELS);
    localparam logic [LCW-1:0]    MAXL     = LCW'(MAX_LEVELS);

    logic                mode_reg;
    logic [LCNT_W-1:0]   lcnt_reg;
    logic [PTR_W-1:0]    head_reg [MAX_LEVELS];
    logic [PTR_W-1:0]    head_next [MAX_LEVELS];
    logic [PTR_W-1:0]    tail_reg [MAX_LEVELS];
    logic [PTR_W-1:0]    tail_next [MAX_LEVELS];
    logic [FILL_W-1:0]   fill_reg [MAX_LEVELS];
    logic [FILL_W-1:0]   fill_next [MAX_LEVELS];
    logic [TOT_W-1:0]    total_reg;
    logic [TOT_W-1:0]    total_next;

    logic [LCW-1:0]      n_act;
    logic [PRIO_W-1:0]   push_lvl_wide;
    logic [LVL_W-1:0]    push_lvl;
    logic                push_bad;
    logic                push_full;
    logic                push_ok;
    logic [LVL_W-1:0]    pop_lvl;
    logic                pop_found;
    logic                pop_ok;
    logic [LCW-1:0]      high_lvl;
    status_t             status_c;

    // Number of levels in use: one in single-level mode, zero taken as one, large counts clamped.
    always_comb
    begin
        if (!mode_reg)
        begin
            n_act = LCW'(1);
        end
        else if (lcnt_reg == '0)
        begin
            n_act = LCW'(1);
        end
        else if ({4'b0000, lcnt_reg} > MAXL_8)
        begin
            n_act = MAXL;
        end
        else
        begin
            n_act = LCW'(lcnt_reg);
        end
    end

    // Push checks: level in range and level not full.
    always_comb
    begin
        push_lvl_wide = mode_reg ? priority_req : '0;
        push_lvl      = push_lvl_wide[LVL_W-1:0];
        push_bad      = ({4'b0000, push_lvl_wide} >= 8'(n_act));
        push_full     = !push_bad && (fill_reg[push_lvl] == FILL_MAX);
        push_ok       = (opcode_t'(opcode) == OP_PUSH) && !push_bad && !push_full;
    end

    // Pop source: the lowest-numbered non-empty level in use.
    always_comb
    begin
        pop_lvl   = '0;
        pop_found = 1'b0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            if ((fill_reg[i] != '0) && (LCW'(i) < n_act))
            begin
                pop_lvl   = LVL_W'(i);
                pop_found = 1'b1;
            end
        end
        pop_ok = (opcode_t'(opcode) == OP_POP) && pop_found;
    end

    // Next pointer, fill and total values for an accepted transaction.
    always_comb
    begin
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            fill_next[i] = fill_reg[i];
        end
        total_next = total_reg;
        if (accept && push_ok)
        begin
            tail_next[push_lvl] = (tail_reg[push_lvl] == PTR_LAST) ? '0
                                : tail_reg[push_lvl] + PTR_W'(1);
            fill_next[push_lvl] = fill_reg[push_lvl] + FILL_W'(1);
            total_next          = total_reg + TOT_W'(1);
        end
        else if (accept && pop_ok)
        begin
            head_next[pop_lvl] = (head_reg[pop_lvl] == PTR_LAST) ? '0
                               : head_reg[pop_lvl] + PTR_W'(1);
            fill_next[pop_lvl] = fill_reg[pop_lvl] - FILL_W'(1);
            total_next         = total_reg - TOT_W'(1);
        end
    end

    // Lowest non-empty level after the step, or the level count when none is.
    always_comb
    begin
        high_lvl = n_act;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            if ((fill_next[i] != '0) && (LCW'(i) < n_act))
            begin
                high_lvl = LCW'(i);
            end
        end
    end

    // Result record for the transaction.
    always_comb
    begin
        if (opcode_t'(opcode) == OP_PUSH)
        begin
            if (push_bad)
            begin
                status_c = ST_BAD_PRIO;
            end
            else if (push_full)
            begin
                status_c = ST_FULL;
            end
            else
            begin
                status_c = ST_OK;
            end
        end
        else
        begin
            status_c = pop_found ? ST_OK : ST_EMPTY;
        end
        res_next.status        = status_c;
        res_next.pop_ok        = pop_ok;
        res_next.popped_level  = pop_ok ? PLVL_W'(pop_lvl) : '0;
        res_next.highest_level = HLVL_W'(high_lvl);
        res_next.waiting_total = WAIT_W'(total_next);
    end

    // Id store requests: write at the tail on push, read the head on pop.
    assign ram_we    = accept && push_ok;
    assign ram_waddr = AW'(push_lvl) * AW'(LEVEL_DEPTH) + AW'(tail_reg[push_lvl]);
    assign ram_wdata = process_id;
    assign ram_re    = accept && pop_ok;
    assign ram_raddr = AW'(pop_lvl) * AW'(LEVEL_DEPTH) + AW'(head_reg[pop_lvl]);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            lcnt_reg <= LCNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:
                begin
                    mode_reg <= cfg_data[0];
                end
                CFG_LEVELS:
                begin
                    lcnt_reg <= cfg_data[LCNT_W-1:0];
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    // Per-level pointers and fill counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                fill_reg[i] <= fill_next[i];
            end
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/multilevel_ready_queue_core.sv @@
// The done strobe follows an accepted command (start high, busy low) in the next cycle.
// Throughput: one command per cycle; busy stays low.
// Results are shown for one cycle on done and cannot be held off by the receiver.
// Reset (rst_n, asynchronous, active low) empties all levels and selects single-level mode
// with a level count of one; the id store needs no clearing pass.
// Depends on mlrq_pkg, mlrq_ctrl and mlrq_ram.
`default_nettype none

module multilevel_ready_queue_core #(
    parameter int MAX_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [mlrq_pkg::OPCODE_W-1:0]       opcode,
    input  wire logic [mlrq_pkg::PID_W-1:0]          process_id,
    input  wire logic [mlrq_pkg::PRIO_W-1:0]         priority_req,
    output logic                                     done,
    output logic [mlrq_pkg::STATUS_W-1:0]            status,
    output logic [mlrq_pkg::PID_W-1:0]               popped_id,
    output logic [mlrq_pkg::PLVL_W-1:0]              popped_level,
    output logic [mlrq_pkg::HLVL_W-1:0]              highest_level,
    output logic [mlrq_pkg::WAIT_W-1:0]              waiting_total,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mlrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mlrq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import mlrq_pkg::*;

    localparam int AW = $clog2(MAX_LEVELS * LEVEL_DEPTH);

    logic              accept;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PID_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [PID_W-1:0]  ram_rdata;
    res_t              res_next;
    res_t              res_reg;
    logic              done_reg;

    // Commands and configuration writes are taken in every cycle.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    mlrq_ctrl #(
        .MAX_LEVELS  (MAX_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .opcode       (opcode),
        .process_id   (process_id),
        .priority_req (priority_req),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .res_next     (res_next)
    );

    mlrq_ram #(
        .WIDTH (PID_W),
        .DEPTH (MAX_LEVELS * LEVEL_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // Result record, aligned with the id store read data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // Result ports; the popped id is zero unless a pop succeeded.
    assign done          = done_reg;
    assign status        = res_reg.status;
    assign popped_id     = res_reg.pop_ok ? ram_rdata : '0;
    assign popped_level  = res_reg.popped_level;
    assign highest_level = res_reg.highest_level;
    assign waiting_total = res_reg.waiting_total;

endmodule

`default_nettype wire

@@ rtl/core/mlrq_checker.sv @@
// Port-level checks for multilevel_ready_queue_core, attached by a bind statement.
// Depends on mlrq_pkg.
`default_nettype none

module mlrq_checker #(
    parameter int MAX_LEVELS = 8
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic [mlrq_pkg::OPCODE_W-1:0]       opcode,
    input wire logic                                done,
    input wire logic [mlrq_pkg::STATUS_W-1:0]       status,
    input wire logic [mlrq_pkg::PID_W-1:0]          popped_id,
    input wire logic [mlrq_pkg::PLVL_W-1:0]         popped_level,
    input wire logic [mlrq_pkg::HLVL_W-1:0]         highest_level,
    input wire logic [mlrq_pkg::WAIT_W-1:0]         waiting_total
);

    import mlrq_pkg::*;

    logic past_valid_reg;

    // Marks cycles whose previous cycle was already out of reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            past_valid_reg <= 1'b0;
        end
        else
        begin
            past_valid_reg <= 1'b1;
        end
    end

    // Every accepted transaction gives exactly one result in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        past_valid_reg |-> (done == $past(start && !busy)))
        else $error("result strobe does not follow the accepted transaction");

    // A failed command carries no popped id or level.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((popped_id == '0) && (popped_level == '0)))
        else $error("failed command reports a popped entry");

    // A push never reports an empty queue, and a pop never reports a priority error.
    a_status_op: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((($past(opcode) == OP_PUSH) && (status != ST_EMPTY)) ||
                  (($past(opcode) == OP_POP) &&
                   ((status == ST_OK) || (status == ST_EMPTY)))))
        else $error("status does not fit the operation");

    // The reported level never exceeds the number of levels.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(highest_level) <= MAX_LEVELS))
        else $error("highest level out of range");

    // Back-to-back results change the waiting count by at most one.
    a_wait_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && past_valid_reg && $past(done)) |->
            ((waiting_total == $past(waiting_total)) ||
             (waiting_total == WAIT_W'($past(waiting_total) + WAIT_W'(1))) ||
             (waiting_total == WAIT_W'($past(waiting_total) - WAIT_W'(1)))))
        else $error("waiting count jumped by more than one");

endmodule

bind multilevel_ready_queue_core mlrq_checker #(
    .MAX_LEVELS (MAX_LEVELS)
) u_mlrq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .done          (done),
    .status        (status),
    .popped_id     (popped_id),
    .popped_level  (popped_level),
    .highest_level (highest_level),
    .waiting_total (waiting_total)
);

`default_nettype wire
